### hw/rtl/pdrt_pkg.sv
// Package for the programmable delay relay timer.
// Holds the mode codes, event kinds, reset constants and the result record.
// No dependencies; every other file of the block imports it.
package pdrt_pkg;

    // Default width of the tick counter.
    localparam int COUNT_BITS_DEFAULT = 8;

    // Width of the stored settings.
    localparam int SET_W = 8;

    // Reset values of the settings.
    localparam logic [SET_W-1:0] HOLD_RESET  = 8'd9;
    localparam logic [SET_W-1:0] DELAY_RESET = 8'd91;
    localparam logic [SET_W-1:0] LATCH_RESET = 8'd11;

    // Event kinds carried in the operation field.
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_EDGE = 1'b1;

    // Operating modes as reported in mode_code.
    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_ARMED  = 3'd1,
        MODE_CLOSED = 3'd2,
        MODE_PWAIT  = 3'd3,
        MODE_PDELAY = 3'd4,
        MODE_PLATCH = 3'd5
    } mode_t;

    // One result item, as produced for every accepted event.
    typedef struct packed {
        logic             settings_changed;
        logic             trigger_polarity;
        logic [SET_W-1:0] latch_ticks;
        logic [SET_W-1:0] delay_ticks;
        logic             led_long;
        logic [1:0]       led_blinks;
        logic [2:0]       mode_code;
        logic             relay_on;
    } result_t;

    // Width of the result bits before padding to whole bytes.
    localparam int RESULT_W = $bits(result_t);
    localparam int OUT_DATA_W = ((RESULT_W + 7) / 8) * 8;

endpackage

### hw/rtl/pdrt_core.sv
// State and event logic of the delay relay timer.
// Holds the mode, tick counter, settings and relay, and forms one result per event.
// Depends on pdrt_pkg.
module pdrt_core #(
    parameter int COUNT_BITS = pdrt_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    input  logic [pdrt_pkg::SET_W-1:0]   cfg_data,
    input  logic                         accept,
    input  logic                         operation,
    input  logic                         switch_pressed,
    input  logic                         trigger_level,
    output pdrt_pkg::result_t            result
);
    import pdrt_pkg::*;

    // Compares run at the wider of the counter and the setting width.
    localparam int CMP_W = (COUNT_BITS > SET_W) ? COUNT_BITS : SET_W;

    logic [SET_W-1:0]      hold_reg;
    mode_t                 mode_reg,  mode_next;
    logic [COUNT_BITS-1:0] tick_reg,  tick_next;
    logic [SET_W-1:0]      delay_reg, delay_next;
    logic [SET_W-1:0]      latch_reg, latch_next;
    logic                  pol_reg,   pol_next;
    logic                  relay_reg, relay_next;
    logic                  changed;

    logic [COUNT_BITS-1:0] tick_inc;
    logic [CMP_W-1:0]      tick_ext;
    logic [SET_W-1:0]      tick_low;
    logic                  prog;
    logic [1:0]            phase;

    // Incremented counter, widened for compares and cut down for storage.
    assign tick_inc = tick_reg + COUNT_BITS'(1);
    assign tick_ext = CMP_W'(tick_inc);
    assign tick_low = tick_ext[SET_W-1:0];

    // Next state for one event.
    always_comb
    begin
        mode_next  = mode_reg;
        tick_next  = tick_reg;
        delay_next = delay_reg;
        latch_next = latch_reg;
        pol_next   = pol_reg;
        relay_next = relay_reg;
        changed    = 1'b0;
        if (operation == OP_EDGE)
        begin
            if (mode_reg == MODE_PWAIT)
            begin
                pol_next  = trigger_level;
                changed   = 1'b1;
                mode_next = MODE_PDELAY;
                tick_next = '0;
            end
            else if (mode_reg == MODE_IDLE && trigger_level == pol_reg)
            begin
                mode_next = MODE_ARMED;
                tick_next = '0;
            end
        end
        else
        begin
            tick_next = tick_inc;
            case (mode_reg)
                MODE_IDLE:
                begin
                    if (!switch_pressed)
                    begin
                        tick_next = '0;
                    end
                    else if (tick_ext == CMP_W'(hold_reg))
                    begin
                        mode_next = MODE_PWAIT;
                    end
                end
                MODE_ARMED:
                begin
                    if (tick_ext == CMP_W'(delay_reg))
                    begin
                        mode_next  = MODE_CLOSED;
                        relay_next = 1'b1;
                        tick_next  = '0;
                    end
                end
                MODE_CLOSED:
                begin
                    if (tick_ext == CMP_W'(latch_reg))
                    begin
                        mode_next  = MODE_IDLE;
                        relay_next = 1'b0;
                        tick_next  = '0;
                    end
                end
                MODE_PWAIT:
                begin
                    mode_next = MODE_PWAIT;
                end
                MODE_PDELAY:
                begin
                    if (switch_pressed)
                    begin
                        mode_next  = MODE_PLATCH;
                        delay_next = tick_low;
                        changed    = 1'b1;
                        relay_next = 1'b1;
                        tick_next  = '0;
                    end
                end
                MODE_PLATCH:
                begin
                    if (!switch_pressed)
                    begin
                        mode_next  = MODE_IDLE;
                        latch_next = tick_low;
                        changed    = 1'b1;
                        relay_next = 1'b0;
                        tick_next  = '0;
                    end
                end
                default:
                begin
                    mode_next = MODE_IDLE;
                end
            endcase
        end
    end

    // State registers advance only on an accepted transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            tick_reg  <= '0;
            delay_reg <= DELAY_RESET;
            latch_reg <= LATCH_RESET;
            pol_reg   <= 1'b0;
            relay_reg <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            tick_reg  <= tick_next;
            delay_reg <= delay_next;
            latch_reg <= latch_next;
            pol_reg   <= pol_next;
            relay_reg <= relay_next;
        end
    end

    // Hold-time register written from the configuration channel.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg <= HOLD_RESET;
        end
        else if (cfg_valid)
        begin
            hold_reg <= cfg_data;
        end
    end

    // LED pattern: phase within the normal or programming group.
    always_comb
    begin
        prog  = 1'b0;
        phase = 2'd0;
        case (mode_next)
            MODE_IDLE:   phase = 2'd0;
            MODE_ARMED:  phase = 2'd1;
            MODE_CLOSED: phase = 2'd2;
            MODE_PWAIT:
            begin
                prog  = 1'b1;
                phase = 2'd0;
            end
            MODE_PDELAY:
            begin
                prog  = 1'b1;
                phase = 2'd1;
            end
            MODE_PLATCH:
            begin
                prog  = 1'b1;
                phase = 2'd2;
            end
            default:     phase = 2'd0;
        endcase
    end

    // Result record for the event being accepted.
    always_comb
    begin
        result.relay_on         = relay_next;
        result.mode_code        = mode_next;
        result.led_blinks       = phase + 2'd1;
        result.led_long         = prog;
        result.delay_ticks      = delay_next;
        result.latch_ticks      = latch_next;
        result.trigger_polarity = pol_next;
        result.settings_changed = changed;
    end

endmodule

### hw/rtl/pdrt_out_buf.sv
// Two-entry output buffer of the delay relay timer.
// Decouples the result register from a stalled receiver; depends on pdrt_pkg.
module pdrt_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  pdrt_pkg::result_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output pdrt_pkg::result_t out_data
);
    import pdrt_pkg::*;

    result_t    mem_reg [2];
    logic [1:0] count_reg, count_next;
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic       push;
    logic       pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_data  = mem_reg[rd_ptr_reg];

    // Occupancy after this cycle's push and pop.
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    // Result storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

### hw/rtl/programmable_delay_relay_timer_top.sv
// Top level of the programmable delay relay timer.
// Instantiates pdrt_core and pdrt_out_buf; depends on pdrt_pkg.
//
// Usage:
//   The slave channel carries one event per transaction: s_tuser is the
//   event kind (0 timer tick, 1 trigger edge), s_tdata holds the switch
//   level and the trigger level. Every accepted event yields exactly one
//   result transaction on the master channel with the relay drive, mode,
//   LED pattern and the current settings.
//   The configuration channel writes the switch hold time for entering
//   programming mode; cfg_ready is always high.
// Throughput:
//   Results are registered in the output buffer. One event is accepted
//   every cycle while s_tready is high; the event logic updates the state
//   in the accepting cycle, so successive events do not wait on each other.
// Stalls:
//   Results go through a two-entry buffer. While the receiver holds
//   m_tready low, events are still accepted until both entries are full,
//   and then s_tready drops until a result is taken.
// Reset:
//   rst_n clears the buffer, returns to wait mode with the relay open, and
//   restores delay 91, latch 11, falling-edge polarity and hold time 9.
module programmable_delay_relay_timer_top #(
    parameter int COUNT_BITS = pdrt_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Configuration write channel: hold time in ticks.
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pdrt_pkg::SET_W-1:0]        cfg_data,
    // Event channel.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // s_tdata: [0] switch_pressed, [1] trigger_level, [7:2] zero.
    input  logic [7:0]                        s_tdata,
    // s_tuser: [0] operation.
    input  logic                              s_tuser,
    // Result channel.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata: [0] relay_on, [3:1] mode_code, [5:4] led_blinks, [6] led_long,
    // [14:7] delay_ticks, [22:15] latch_ticks, [23] trigger_polarity,
    // [24] settings_changed, [31:25] zero.
    output logic [pdrt_pkg::OUT_DATA_W-1:0]  m_tdata
);
    import pdrt_pkg::*;

    logic    accept;
    result_t core_result;
    result_t buf_result;

    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;

    // Event logic and state.
    pdrt_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_data       (cfg_data),
        .accept         (accept),
        .operation      (s_tuser),
        .switch_pressed (s_tdata[0]),
        .trigger_level  (s_tdata[1]),
        .result         (core_result)
    );

    // Result buffer toward the receiver.
    pdrt_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (core_result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (buf_result)
    );

    // Pack the result with zero padding to whole bytes.
    assign m_tdata = OUT_DATA_W'(buf_result);

endmodule

### hw/rtl/pdrt_checker.sv
// Port-level checks for the programmable delay relay timer.
// Bound to programmable_delay_relay_timer_top; depends on pdrt_pkg.
module pdrt_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [pdrt_pkg::OUT_DATA_W-1:0] m_tdata
);
    import pdrt_pkg::*;

    // A stalled result transaction keeps its data.
    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Only the six defined modes are reported.
    a_mode_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[3:1] <= MODE_PLATCH))
        else $error("undefined mode reported");

    // Long LED pulses go with the programming modes only.
    a_led_long: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[6] == (m_tdata[3:1] >= MODE_PWAIT)))
        else $error("led_long does not match mode");

    // The relay is closed only in a latch mode.
    a_relay_mode: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |->
            (m_tdata[3:1] == MODE_CLOSED) || (m_tdata[3:1] == MODE_PLATCH))
        else $error("relay closed outside a latch mode");

endmodule

bind programmable_delay_relay_timer_top pdrt_checker u_pdrt_checker (.*);

### bench/testbench.sv
// Testbench for programmable_delay_relay_timer_top: directed and random event streams.
// The expected results come from a predictor of the relay controller kept in this file.
// Depends on pdrt_pkg and the RTL of the block.
`timescale 1ns / 100ps

module testbench;

    import pdrt_pkg::*;

    localparam int CNT_W     = COUNT_BITS_DEFAULT;
    localparam int LONG_HOLD = 300;

    // Clock, reset and block ports.
    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [SET_W-1:0]      cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // s_tdata: [0] switch_pressed, [1] trigger_level, [7:2] zero.
    logic [7:0]            s_tdata = '0;
    // s_tuser: [0] operation.
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // m_tdata: [0] relay_on, [3:1] mode_code, [5:4] led_blinks, [6] led_long,
    // [14:7] delay_ticks, [22:15] latch_ticks, [23] trigger_polarity,
    // [24] settings_changed, [31:25] zero.
    logic [OUT_DATA_W-1:0] m_tdata;

    // Predicted controller state.
    mode_t            relay_mode = MODE_IDLE;
    logic [CNT_W-1:0] relay_ticks = '0;
    logic [SET_W-1:0] relay_delay = DELAY_RESET;
    logic [SET_W-1:0] relay_latch = LATCH_RESET;
    logic             relay_polarity = 1'b0;
    logic             relay_closed = 1'b0;
    logic [SET_W-1:0] relay_hold = HOLD_RESET;

    // Results still to arrive, oldest first.
    result_t relay_expected[$];

    int  fail_count = 0;
    int  items_sent = 0;
    bit  idle_enabled = 1'b1;
    int  long_hold_start = 0;
    int  long_hold_seen = 0;
    int  long_hold_left = 0;
    int  stall_left = 0;

    programmable_delay_relay_timer_top #(
        .COUNT_BITS (CNT_W)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // 8 ns clock.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Safety net against a hung run.
    initial
    begin
        #(4_000_000);
        $display("== FAIL ==");
        $finish;
    end

    // Advances the predicted state by one event and returns the expected result.
    function automatic result_t relay_step(input logic op, input logic sw, input logic trg);
        result_t r;
        logic    changed;
        logic    prog;
        changed = 1'b0;
        if (op == OP_EDGE)
        begin
            if (relay_mode == MODE_PWAIT)
            begin
                relay_polarity = trg;
                changed = 1'b1;
                relay_mode = MODE_PDELAY;
                relay_ticks = '0;
            end
            else if (relay_mode == MODE_IDLE && trg == relay_polarity)
            begin
                relay_mode = MODE_ARMED;
                relay_ticks = '0;
            end
        end
        else
        begin
            // Every tick counts first, then the mode is evaluated.
            relay_ticks = relay_ticks + 1'b1;
            case (relay_mode)
                MODE_IDLE:
                begin
                    if (!sw)
                        relay_ticks = '0;
                    else if (int'(relay_ticks) == int'(relay_hold))
                        relay_mode = MODE_PWAIT;
                end
                MODE_ARMED:
                begin
                    if (int'(relay_ticks) == int'(relay_delay))
                    begin
                        relay_mode = MODE_CLOSED;
                        relay_closed = 1'b1;
                        relay_ticks = '0;
                    end
                end
                MODE_CLOSED:
                begin
                    if (int'(relay_ticks) == int'(relay_latch))
                    begin
                        relay_mode = MODE_IDLE;
                        relay_closed = 1'b0;
                        relay_ticks = '0;
                    end
                end
                MODE_PWAIT:
                begin
                end
                MODE_PDELAY:
                begin
                    if (sw)
                    begin
                        relay_mode = MODE_PLATCH;
                        relay_delay = SET_W'(relay_ticks);
                        changed = 1'b1;
                        relay_closed = 1'b1;
                        relay_ticks = '0;
                    end
                end
                MODE_PLATCH:
                begin
                    if (!sw)
                    begin
                        relay_mode = MODE_IDLE;
                        relay_latch = SET_W'(relay_ticks);
                        changed = 1'b1;
                        relay_closed = 1'b0;
                        relay_ticks = '0;
                    end
                end
                default:
                begin
                    relay_mode = MODE_IDLE;
                end
            endcase
        end

        // Report the LED pattern for the mode group.
        prog = (relay_mode >= MODE_PWAIT && relay_mode <= MODE_PLATCH);
        r = '0;
        r.relay_on = relay_closed;
        r.mode_code = relay_mode;
        if (relay_mode > MODE_PLATCH)
            r.led_blinks = 2'd1;
        else if (prog)
            r.led_blinks = 2'(relay_mode - MODE_PWAIT + 1);
        else
            r.led_blinks = 2'(relay_mode + 1);
        r.led_long = prog;
        r.delay_ticks = relay_delay;
        r.latch_ticks = relay_latch;
        r.trigger_polarity = relay_polarity;
        r.settings_changed = changed;
        return r;
    endfunction

    // Offers one event and waits for its transaction, then maybe idles.
    task automatic send_event(input logic op, input logic sw, input logic trg);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {6'b0, trg, sw};
        do
            @(posedge clk);
        while (!s_tready);
        relay_expected.push_back(relay_step(op, sw, trg));
        items_sent++;
        gap = 0;
        if (idle_enabled && $urandom_range(0, 5) == 0)
            gap = $urandom_range(1, 14);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stops offering events and waits until every expected result has come.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (relay_expected.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    // Writes the hold time; called only while the block is idle.
    task automatic write_hold(input logic [SET_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        relay_hold = value;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Mostly small times, now and then the wrap cases that store 0 and 255.
    function automatic int pick_time();
        case ($urandom_range(0, 23))
            0: return 255;
            1: return 254;
            default: return $urandom_range(0, 5);
        endcase
    endfunction

    function automatic logic coin();
        return 1'($urandom_range(0, 1));
    endfunction

    // Drives whatever events bring the controller back to wait mode.
    task automatic return_to_wait();
        while (relay_mode != MODE_IDLE)
        begin
            case (relay_mode)
                MODE_PWAIT:  send_event(OP_EDGE, coin(), coin());
                MODE_PDELAY: send_event(OP_TICK, 1'b1, coin());
                MODE_PLATCH: send_event(OP_TICK, 1'b0, coin());
                default:     send_event(OP_TICK, coin(), coin());
            endcase
        end
    endtask

    // A full programming pass: hold, polarity, delay and latch.
    task automatic program_sequence();
        int k;
        return_to_wait();
        send_event(OP_TICK, 1'b0, coin());
        for (int i = 0; i < int'(relay_hold); i++)
        begin
            // An edge of the other polarity must not disturb the hold count.
            if ($urandom_range(0, 9) == 0)
                send_event(OP_EDGE, coin(), ~relay_polarity);
            send_event(OP_TICK, 1'b1, coin());
        end
        if (relay_mode != MODE_PWAIT)
            return;
        repeat ($urandom_range(0, 3)) send_event(OP_TICK, coin(), coin());
        send_event(OP_EDGE, coin(), coin());
        k = pick_time();
        repeat (k)
        begin
            if ($urandom_range(0, 11) == 0)
                send_event(OP_EDGE, coin(), coin());
            send_event(OP_TICK, 1'b0, coin());
        end
        send_event(OP_TICK, 1'b1, coin());
        k = pick_time();
        repeat (k)
        begin
            if ($urandom_range(0, 11) == 0)
                send_event(OP_EDGE, coin(), coin());
            send_event(OP_TICK, 1'b1, coin());
        end
        send_event(OP_TICK, 1'b0, coin());
    endtask

    // A normal relay cycle started by an edge of the stored polarity.
    task automatic relay_cycle();
        return_to_wait();
        send_event(OP_EDGE, coin(), relay_polarity);
        while (relay_mode != MODE_IDLE)
        begin
            if ($urandom_range(0, 5) == 0)
                send_event(OP_EDGE, coin(), coin());
            else
                send_event(OP_TICK, coin(), coin());
        end
    endtask

    task automatic noise_burst();
        repeat ($urandom_range(5, 15)) send_event(coin(), coin(), coin());
    endtask

    // Compares one result field and records a mismatch.
    task automatic check_field(input string name, input int exp, input int act);
        if (exp != act)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp, act);
            fail_count++;
        end
    endtask

    task automatic compare_result(input result_t exp, input logic [OUT_DATA_W-1:0] raw);
        result_t got;
        got = raw[RESULT_W-1:0];
        check_field("relay_on", exp.relay_on, got.relay_on);
        check_field("mode_code", exp.mode_code, got.mode_code);
        check_field("led_blinks", exp.led_blinks, got.led_blinks);
        check_field("led_long", exp.led_long, got.led_long);
        check_field("delay_ticks", exp.delay_ticks, got.delay_ticks);
        check_field("latch_ticks", exp.latch_ticks, got.latch_ticks);
        check_field("trigger_polarity", exp.trigger_polarity, got.trigger_polarity);
        check_field("settings_changed", exp.settings_changed, got.settings_changed);
        check_field("padding", 0, int'(raw[OUT_DATA_W-1:RESULT_W]));
    endtask

    // Checks each result transaction against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (relay_expected.size() == 0)
            begin
                $error("result transaction with no expected result: %h", m_tdata);
                fail_count++;
            end
            else
            begin
                compare_result(relay_expected.pop_front(), m_tdata);
            end
        end
    end

    // Receiver: random stall bursts, plus a long hold-off on request.
    always @(posedge clk)
    begin
        if (long_hold_start != long_hold_seen)
        begin
            long_hold_seen <= long_hold_start;
            long_hold_left <= LONG_HOLD - 1;
            m_tready <= 1'b0;
        end
        else if (long_hold_left > 0)
        begin
            long_hold_left <= long_hold_left - 1;
            m_tready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end
        else if (idle_enabled && $urandom_range(0, 9) == 0)
        begin
            stall_left <= $urandom_range(0, 13);
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    // Reset state: wrong-polarity edge, switch held and released in wait.
    task automatic test_reset_state();
        send_event(OP_TICK, 1'b0, 1'b0);
        send_event(OP_EDGE, 1'b0, 1'b1);
        send_event(OP_TICK, 1'b1, 1'b0);
        send_event(OP_TICK, 1'b1, 1'b1);
        send_event(OP_TICK, 1'b1, 1'b0);
        send_event(OP_TICK, 1'b0, 1'b1);
    endtask

    // Programming with a one-tick hold: polarity rising, delay 2, latch 3.
    task automatic test_programming();
        drain_results();
        write_hold(8'd1);
        send_event(OP_TICK, 1'b1, 1'b0);
        send_event(OP_TICK, 1'b0, 1'b0);
        send_event(OP_TICK, 1'b1, 1'b1);
        send_event(OP_EDGE, 1'b0, 1'b1);
        send_event(OP_EDGE, 1'b1, 1'b0);
        send_event(OP_TICK, 1'b0, 1'b0);
        send_event(OP_TICK, 1'b1, 1'b0);
        send_event(OP_EDGE, 1'b1, 1'b1);
        send_event(OP_TICK, 1'b1, 1'b0);
        send_event(OP_TICK, 1'b1, 1'b1);
        send_event(OP_TICK, 1'b0, 1'b0);
    endtask

    // Normal cycle on the programmed rising polarity, with ignored edges.
    task automatic test_relay_cycle();
        send_event(OP_EDGE, 1'b0, 1'b0);
        send_event(OP_EDGE, 1'b0, 1'b1);
        send_event(OP_EDGE, 1'b1, 1'b1);
        send_event(OP_TICK, 1'b1, 1'b0);
        send_event(OP_TICK, 1'b0, 1'b1);
        send_event(OP_EDGE, 1'b0, 1'b0);
        send_event(OP_TICK, 1'b0, 1'b0);
        send_event(OP_TICK, 1'b1, 1'b1);
        send_event(OP_TICK, 1'b1, 1'b0);
    endtask

    // Largest hold time, then back to the reset value.
    task automatic test_hold_extremes();
        return_to_wait();
        drain_results();
        write_hold(8'd255);
        send_event(OP_TICK, 1'b0, 1'b0);
        repeat (255) send_event(OP_TICK, 1'b1, coin());
        return_to_wait();
        drain_results();
        write_hold(HOLD_RESET);
    endtask

    // The receiver holds off while events keep coming, so the input stalls.
    task automatic test_backpressure();
        drain_results();
        idle_enabled = 1'b0;
        long_hold_start++;
        repeat (40) send_event(coin(), coin(), coin());
        drain_results();
        idle_enabled = 1'b1;
    endtask

    task automatic test_random_mix();
        while (items_sent < 1650)
        begin
            idle_enabled = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 9))
                0, 1, 2, 3: program_sequence();
                4, 5, 6, 7: relay_cycle();
                8:          noise_burst();
                default:
                begin
                    return_to_wait();
                    drain_results();
                    case ($urandom_range(0, 7))
                        0:       write_hold(8'd1);
                        1:       write_hold(SET_W'($urandom_range(13, 40)));
                        default: write_hold(SET_W'($urandom_range(2, 12)));
                    endcase
                end
            endcase
        end
    endtask

    // Closing stretch without any idling on either side.
    task automatic test_quiet_finish();
        idle_enabled = 1'b0;
        program_sequence();
        relay_cycle();
        noise_burst();
        relay_cycle();
        return_to_wait();
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_programming();
        test_relay_cycle();
        test_hold_extremes();
        test_backpressure();
        test_random_mix();
        test_quiet_finish();
        drain_results();
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
